[src/double_to_width_integer_unit_assert.svh]
// assertion macros for the double to integer conversion unit
`ifndef DOUBLE_TO_WIDTH_INTEGER_UNIT_ASSERT_SVH
`define DOUBLE_TO_WIDTH_INTEGER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define DTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/dtw_pkg.sv]
// shared types for the double to integer conversion unit
`timescale 1ns / 1ps
package dtw_pkg;
    localparam logic [2:0] RM_UP   = 3'd0;
    localparam logic [2:0] RM_DOWN = 3'd1;
    localparam logic [2:0] RM_ZERO = 3'd2;
    localparam logic [2:0] RM_AWAY = 3'd3;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [2:0]  rounding_mode;
        logic [6:0]  target_width;
        logic        unsigned_target;
        logic        report_inexact;
    } dtw_in_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        invalid_flag;
        logic        inexact_flag;
    } dtw_out_t;

    // stage 1 to stage 2: decoded operand
    typedef struct packed {
        logic        neg;
        logic        bad;
        logic        big;
        logic [52:0] man;
        logic [11:0] ex;
        logic [2:0]  mode;
        logic [6:0]  width;
        logic        uns;
        logic        rep;
    } dtw_dec_t;

    // stage 2 to stage 3: shifted magnitude with rounding decision
    typedef struct packed {
        logic        neg;
        logic        bad;
        logic [63:0] mag;
        logic        up;
        logic        frac;
        logic [6:0]  width;
        logic        uns;
        logic        rep;
    } dtw_rnd_t;
endpackage

[src/dtw_decode.sv]
// stage 1: field split and special case detection
`timescale 1ns / 1ps
module dtw_decode import dtw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     vin,
    input  dtw_in_t  din,
    output logic     vout,
    output dtw_dec_t dout
);
    logic     valid_reg;
    dtw_dec_t data_reg, data_next;
    logic [10:0] ex;

    // decode fields
    always_comb
    begin
        ex = din.value_bits[62:52];
        data_next.neg   = din.value_bits[63];
        data_next.bad   = (ex == 11'h7FF) || (din.target_width == 7'd0);
        data_next.big   = ({1'b0, ex} >= 12'd1087);
        data_next.man   = {ex != 11'd0, din.value_bits[51:0]};
        data_next.ex    = (ex == 11'd0) ? 12'd1 : {1'b0, ex};
        data_next.mode  = din.rounding_mode;
        data_next.width = (din.target_width > 7'd64) ? 7'd64 : din.target_width;
        data_next.uns   = din.unsigned_target;
        data_next.rep   = din.report_inexact;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign vout = valid_reg;
    assign dout = data_reg;
endmodule

[src/dtw_round.sv]
// stage 2: alignment shift and rounding decision
`timescale 1ns / 1ps
module dtw_round import dtw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     vin,
    input  dtw_dec_t din,
    output logic     vout,
    output dtw_rnd_t dout
);
    logic     valid_reg;
    dtw_rnd_t data_reg, data_next;
    logic [116:0] wide;
    logic [63:0]  rem;
    logic [63:0]  half;
    logic [63:0]  mask;
    logic [11:0]  rsh;
    logic [5:0]   r6;
    logic         far;
    logic         gt, eq;

    // man shifted right by 1075 - ex; the bits shifted out decide the fraction and rounding
    always_comb
    begin
        rsh  = 12'd1075 - din.ex;
        r6   = rsh[5:0];
        far  = (din.ex < 12'd1075) && (rsh >= 12'd64);
        wide = '0;
        mask = '0;
        half = '0;
        rem  = '0;
        data_next.mag  = '0;
        data_next.frac = 1'b0;
        gt = 1'b0;
        eq = 1'b0;
        if (din.ex >= 12'd1075)
        begin
            data_next.mag = 64'(din.man) << (din.ex - 12'd1075);
        end
        else if (far)
        begin
            data_next.frac = din.man != '0;
        end
        else
        begin
            mask = (64'd1 << r6) - 64'd1;
            half = 64'd1 << (r6 - 6'd1);
            rem  = 64'(din.man) & mask;
            data_next.mag  = 64'(din.man) >> r6;
            data_next.frac = rem != '0;
            gt = rem > half;
            eq = rem == half;
        end
        data_next.up = 1'b0;
        if (data_next.frac)
        begin
            case (din.mode)
                RM_UP:   data_next.up = !din.neg;
                RM_DOWN: data_next.up = din.neg;
                RM_ZERO: data_next.up = 1'b0;
                RM_AWAY: data_next.up = gt || eq;
                default: data_next.up = gt || (eq && data_next.mag[0]);
            endcase
        end
        data_next.neg   = din.neg;
        data_next.bad   = din.bad || din.big;
        data_next.width = din.width;
        data_next.uns   = din.uns;
        data_next.rep   = din.rep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign vout = valid_reg;
    assign dout = data_reg;
endmodule

[src/dtw_range.sv]
// stage 3: increment and range check
`timescale 1ns / 1ps
module dtw_range import dtw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     vin,
    input  dtw_rnd_t din,
    output logic     vout,
    output dtw_out_t dout
);
    logic     valid_reg;
    dtw_out_t data_reg, data_next;
    logic [64:0] mag;
    logic [64:0] lim;
    logic        fail;

    always_comb
    begin
        mag = {1'b0, din.mag} + {64'd0, din.up};
        lim = 65'd1 << (din.width - 7'd1);
        if (din.uns)
            fail = (din.neg && mag != '0) || (mag > ((65'd1 << din.width) - 65'd1));
        else
            fail = din.neg ? (mag > lim) : (mag > lim - 65'd1);
        fail = fail || din.bad;
        data_next.invalid_flag = fail;
        data_next.result_bits  = fail ? 64'd0 :
                                 (din.neg ? 64'd0 - mag[63:0] : mag[63:0]);
        data_next.inexact_flag = !fail && din.rep && din.frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign vout = valid_reg;
    assign dout = data_reg;

    `include "double_to_width_integer_unit_assert.svh"
    `DTW_ASSERT_IMP(inv_zero_result, clk, rst_n, vout && dout.invalid_flag,
        dout.result_bits == 64'd0 && !dout.inexact_flag, "invalid item not zeroed")
    `DTW_ASSERT_NEXT(hold_on_stall, clk, rst_n, vout && !en, vout && $stable(dout),
        "stalled item changed")
    `DTW_ASSERT_NEXT(advance_item, clk, rst_n, vin && en, vout,
        "advancing item lost")
endmodule

[src/double_to_width_integer_unit.sv]
// Double to integer conversion unit, three stage pipeline.
// Each item passes through the decode, round and range registers in that order.
// Throughput: one item per cycle; the whole pipe advances while the output
// register is empty or being taken, so the last stage sets the rate.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
module double_to_width_integer_unit import dtw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dtw_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output dtw_out_t out_data
);
    logic     en;
    logic     v1, v2;
    dtw_dec_t d1;
    dtw_rnd_t d2;

    // global advance when the output slot frees
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    dtw_decode u_dec (.clk, .rst_n, .en, .vin(in_valid), .din(in_data), .vout(v1), .dout(d1));
    dtw_round  u_rnd (.clk, .rst_n, .en, .vin(v1), .din(d1), .vout(v2), .dout(d2));
    dtw_range  u_rng (.clk, .rst_n, .en, .vin(v2), .din(d2), .vout(out_valid),
                      .dout(out_data));
endmodule
